FILE: hw/rtl/fwrl_pkg.sv
`timescale 1ns / 1ps

package fwrl_pkg;

  localparam int TIME_W  = 32;
  localparam int COUNT_W = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PER_WINDOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LENGTH    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REPORT_INTERVAL = 2'd3;

  localparam logic [TIME_W-1:0]  RST_WINDOW_LENGTH   = 32'd1000;
  localparam logic [COUNT_W-1:0] RST_MAX_PER_WINDOW  = 16'd20;
  localparam logic [TIME_W-1:0]  RST_BLOCK_LENGTH    = 32'd5000;
  localparam logic [TIME_W-1:0]  RST_REPORT_INTERVAL = 32'd5000;

  typedef struct packed {
    logic [TIME_W-1:0]  window_length_ms;
    logic [COUNT_W-1:0] max_per_window;
    logic [TIME_W-1:0]  block_length_ms;
    logic [TIME_W-1:0]  report_interval_ms;
  } cfg_t;

  typedef struct packed {
    logic [TIME_W-1:0]  blocked_until;
    logic [TIME_W-1:0]  window_start;
    logic [COUNT_W-1:0] accepted_in_window;
    logic [TIME_W-1:0]  last_report_time;
    logic [TIME_W-1:0]  rejected_count;
  } state_t;

  typedef struct packed {
    logic              admitted;
    logic              report_rejection;
    logic [TIME_W-1:0] rejected_total;
  } result_t;

endpackage

FILE: hw/rtl/fwrl_decide.sv
`timescale 1ns / 1ps

module fwrl_decide import fwrl_pkg::*; (
  input  cfg_t              cfg,
  input  state_t            state,
  input  logic [TIME_W-1:0] now_ms,
  output state_t            state_nxt,
  output result_t           result
);

  logic [TIME_W-1:0]  lock_diff;
  logic               locked;
  logic [TIME_W-1:0]  report_age;
  logic               report_due;
  logic               was_blocked;
  logic [TIME_W-1:0]  ws_eff;
  logic [COUNT_W-1:0] cnt_eff;
  logic [TIME_W-1:0]  window_age;
  logic               restart;
  logic [COUNT_W-1:0] cnt_win;

  always_comb begin
    lock_diff   = state.blocked_until - now_ms;
    locked      = (state.blocked_until != '0) && (lock_diff != '0) && !lock_diff[TIME_W-1];
    report_age  = now_ms - state.last_report_time;
    report_due  = (state.last_report_time == '0) || (report_age >= cfg.report_interval_ms);
    // an expired lockout reopens the window at this timestamp
    was_blocked = (state.blocked_until != '0);
    ws_eff      = was_blocked ? now_ms : state.window_start;
    cnt_eff     = was_blocked ? '0 : state.accepted_in_window;
    window_age  = now_ms - ws_eff;
    restart     = (ws_eff == '0) || (window_age >= cfg.window_length_ms);
    cnt_win     = restart ? '0 : cnt_eff;

    state_nxt = state;
    result.admitted         = 1'b0;
    result.report_rejection = 1'b0;
    if (locked) begin
      state_nxt.rejected_count = state.rejected_count + 1'b1;
      if (report_due) begin
        state_nxt.last_report_time = now_ms;
        result.report_rejection    = 1'b1;
      end
    end else begin
      state_nxt.window_start = restart ? now_ms : ws_eff;
      if (cnt_win >= cfg.max_per_window) begin
        // burst limit hit: start lockout
        state_nxt.blocked_until      = now_ms + cfg.block_length_ms;
        state_nxt.accepted_in_window = cnt_win;
        state_nxt.last_report_time   = now_ms;
        state_nxt.rejected_count     = state.rejected_count + 1'b1;
        result.report_rejection      = 1'b1;
      end else begin
        state_nxt.blocked_until      = '0;
        state_nxt.accepted_in_window = cnt_win + 1'b1;
        result.admitted              = 1'b1;
      end
    end
    result.rejected_total = state_nxt.rejected_count;
  end

endmodule

FILE: hw/rtl/fixed_window_rate_limiter_lockout.sv
`timescale 1ns / 1ps
// Fixed-window rate limiter with lockout.
// Pipeline: an accepted input is held in the input register, and its decision is then loaded
// into the result register, which raises out_valid; out_ready back-pressure can stall both.
// Throughput: 1 item per cycle while out_ready does not hold a result back; the decision and
// state update are combinational between the input register and the result register.
// Reset (rst_n low, synchronous): state cleared to zero, registers back to defaults,
// both pipeline stages emptied.

module fixed_window_rate_limiter_lockout import fwrl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [TIME_W-1:0]     in_now_ms,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_admitted,
  output logic                  out_report_rejection,
  output logic [TIME_W-1:0]     out_rejected_total,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t              cfg_r;
  state_t            state_r;
  state_t            state_nxt;
  result_t           result_nxt;
  result_t           result_r;
  logic              s1_valid_r;
  logic [TIME_W-1:0] s1_now_r;
  logic              out_valid_r;
  logic              advance;

  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.window_length_ms   <= RST_WINDOW_LENGTH;
      cfg_r.max_per_window     <= RST_MAX_PER_WINDOW;
      cfg_r.block_length_ms    <= RST_BLOCK_LENGTH;
      cfg_r.report_interval_ms <= RST_REPORT_INTERVAL;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WINDOW_LENGTH:   cfg_r.window_length_ms   <= cfg_wdata;
        REG_MAX_PER_WINDOW:  cfg_r.max_per_window     <= cfg_wdata[COUNT_W-1:0];
        REG_BLOCK_LENGTH:    cfg_r.block_length_ms    <= cfg_wdata;
        REG_REPORT_INTERVAL: cfg_r.report_interval_ms <= cfg_wdata;
        default: ;
      endcase
    end
  end

  fwrl_decide u_decide (
    .cfg       (cfg_r),
    .state     (state_r),
    .now_ms    (s1_now_r),
    .state_nxt (state_nxt),
    .result    (result_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        state_r     <= state_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_now_r <= in_now_ms;
    end
    if (advance) begin
      result_r <= result_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_admitted         = result_r.admitted;
  assign out_report_rejection = result_r.report_rejection;
  assign out_rejected_total   = result_r.rejected_total;

endmodule

FILE: hw/rtl/fwrl_checker.sv
`timescale 1ns / 1ps

module fwrl_checker import fwrl_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic              out_admitted,
  input logic              out_report_rejection,
  input logic [TIME_W-1:0] out_rejected_total
);

  logic [TIME_W-1:0] last_total_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_total_r <= '0;
    end else if (out_valid && out_ready) begin
      last_total_r <= out_rejected_total;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_rejected_total)
      && $stable(out_admitted) && $stable(out_report_rejection))
    else $error("result item changed while stalled");

  a_no_report_on_admit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_admitted |-> !out_report_rejection)
    else $error("report raised on an admitted item");

  a_total_admit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_admitted |-> out_rejected_total == last_total_r)
    else $error("rejection total moved on an admitted item");

  a_total_reject: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_admitted |-> out_rejected_total == last_total_r + 1'b1)
    else $error("rejection total did not advance by one on a rejected item");

endmodule

bind fixed_window_rate_limiter_lockout fwrl_checker u_fwrl_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .out_valid            (out_valid),
  .out_ready            (out_ready),
  .out_admitted         (out_admitted),
  .out_report_rejection (out_report_rejection),
  .out_rejected_total   (out_rejected_total)
);
